/* src/m68kea_pkg.sv */
// ----------------------------------------------------------------------------
// m68kea_pkg
// Shared codes and types for the 68000 effective address unit.
// ----------------------------------------------------------------------------
package m68kea_pkg;

    // ea mode field
    localparam logic [2:0] MODE_DN       = 3'd0;
    localparam logic [2:0] MODE_AN       = 3'd1;
    localparam logic [2:0] MODE_ADDR_IND = 3'd2;
    localparam logic [2:0] MODE_POSTINC  = 3'd3;
    localparam logic [2:0] MODE_PREDEC   = 3'd4;
    localparam logic [2:0] MODE_DISP     = 3'd5;
    localparam logic [2:0] MODE_INDEX    = 3'd6;
    localparam logic [2:0] MODE_EXT      = 3'd7;

    // register field under the extended mode
    localparam logic [2:0] EXT_ABS_W    = 3'd0;
    localparam logic [2:0] EXT_ABS_L    = 3'd1;
    localparam logic [2:0] EXT_PC_DISP  = 3'd2;
    localparam logic [2:0] EXT_PC_INDEX = 3'd3;
    localparam logic [2:0] EXT_IMM      = 3'd4;

    // stack pointer register number
    localparam logic [2:0] REG_STACK = 3'd7;

    // operand size
    localparam logic [1:0] OPSZ_BYTE = 2'd0;
    localparam logic [1:0] OPSZ_WORD = 2'd1;
    localparam logic [1:0] OPSZ_LONG = 2'd2;

    // result status
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_ODD     = 2'd2;

    // access direction
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // register file bank select (top address bit)
    localparam logic BANK_DATA = 1'b0;
    localparam logic BANK_ADDR = 1'b1;

    // register file: D0-D7 at 0-7, A0-A7 at 8-15
    typedef logic [3:0]  rf_addr_t;
    typedef logic [31:0] word_t;

    typedef struct packed {
        logic     en;
        rf_addr_t addr;
        word_t    data;
    } rf_write_t;

endpackage

/* src/m68kea_regfile.sv */
// ----------------------------------------------------------------------------
// m68kea_regfile
// D0-D7 / A0-A7 register file: one write port, two registered read ports
// with bypass of a write landing on the same edge.
// ----------------------------------------------------------------------------
module m68kea_regfile (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  m68kea_pkg::rf_addr_t rd_addr_a,
    input  m68kea_pkg::rf_addr_t rd_addr_b,
    output m68kea_pkg::word_t    rd_data_a,
    output m68kea_pkg::word_t    rd_data_b,
    input  m68kea_pkg::rf_write_t wr
);
    import m68kea_pkg::*;

    word_t       rf_reg [16];
    logic [15:0] written_reg;
    logic [15:0] written_next;
    word_t       rd_a_reg;
    word_t       rd_b_reg;

    // entries never written read as zero
    always_comb begin
        written_next = written_reg;
        if (wr.en) begin
            written_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else begin
            written_reg <= written_next;
        end
    end

    // storage write
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            rf_reg[wr.addr] <= wr.data;
        end
    end

    // registered reads, bypassing a write on the same edge
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.en && wr.addr == rd_addr_a) begin
                rd_a_reg <= wr.data;
            end else if (written_reg[rd_addr_a]) begin
                rd_a_reg <= rf_reg[rd_addr_a];
            end else begin
                rd_a_reg <= '0;
            end
            if (wr.en && wr.addr == rd_addr_b) begin
                rd_b_reg <= wr.data;
            end else if (written_reg[rd_addr_b]) begin
                rd_b_reg <= rf_reg[rd_addr_b];
            end else begin
                rd_b_reg <= '0;
            end
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* src/m68kea_calc.sv */
// ----------------------------------------------------------------------------
// m68kea_calc
// Effective address, operand value and register update for one request.
// ----------------------------------------------------------------------------
module m68kea_calc (
    input  logic                  action,
    input  logic [2:0]            mode,
    input  logic [2:0]            reg_req,
    input  logic [1:0]            size,
    input  logic [15:0]           ext_first,
    input  logic [15:0]           ext_second,
    input  m68kea_pkg::word_t     pc,
    input  m68kea_pkg::word_t     write_value,
    input  m68kea_pkg::word_t     base,
    input  m68kea_pkg::word_t     idx_data,
    output logic                  is_memory,
    output m68kea_pkg::word_t     address,
    output m68kea_pkg::word_t     operand_value,
    output logic [1:0]            words_used,
    output logic [1:0]            status,
    output m68kea_pkg::rf_write_t wr
);
    import m68kea_pkg::*;

    function automatic word_t sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic word_t sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic word_t operand_mask(input logic [1:0] sz);
        word_t m;
        case (sz)
            OPSZ_BYTE: m = 32'h0000_00FF;
            OPSZ_WORD: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    logic  invalid;
    word_t step;
    word_t idx_val;
    word_t index_off;
    word_t index_addr;

    // illegal size, unused extended modes, write to an immediate
    assign invalid = !(size inside {OPSZ_BYTE, OPSZ_WORD, OPSZ_LONG})
                   || (mode == MODE_EXT && reg_req > EXT_IMM)
                   || (mode == MODE_EXT && reg_req == EXT_IMM && action == ACT_WRITE);

    // byte steps on the stack pointer keep it even
    always_comb begin
        case (size)
            OPSZ_BYTE: step = (reg_req == REG_STACK) ? 32'd2 : 32'd1;
            OPSZ_WORD: step = 32'd2;
            default:   step = 32'd4;
        endcase
    end

    // brief extension word: index register plus 8-bit displacement
    assign idx_val    = ext_first[11] ? idx_data : sext16(idx_data[15:0]);
    assign index_off  = sext8(ext_first[7:0]) + idx_val;
    assign index_addr = ((mode == MODE_EXT) ? pc : base) + index_off;

    always_comb begin
        is_memory     = 1'b0;
        address       = '0;
        operand_value = '0;
        words_used    = 2'd0;
        status        = STATUS_OK;
        wr            = '0;
        if (invalid) begin
            status = STATUS_INVALID;
        end else if (mode == MODE_DN) begin
            address = {29'd0, reg_req};
            if (action == ACT_WRITE) begin
                wr.en   = 1'b1;
                wr.addr = {BANK_DATA, reg_req};
                case (size)
                    OPSZ_BYTE: wr.data = {base[31:8], write_value[7:0]};
                    OPSZ_WORD: wr.data = {base[31:16], write_value[15:0]};
                    default:   wr.data = write_value;
                endcase
            end else begin
                operand_value = base & operand_mask(size);
            end
        end else if (mode == MODE_AN) begin
            address = {29'd0, reg_req};
            if (action == ACT_WRITE) begin
                wr.en   = 1'b1;
                wr.addr = {BANK_ADDR, reg_req};
                wr.data = write_value;
            end else begin
                operand_value = base;
            end
        end else if (mode == MODE_EXT && reg_req == EXT_IMM) begin
            address = pc;
            if (size == OPSZ_LONG) begin
                operand_value = {ext_first, ext_second};
                words_used    = 2'd2;
            end else begin
                operand_value = {16'd0, ext_first} & operand_mask(size);
                words_used    = 2'd1;
            end
        end else begin
            // memory operand
            is_memory = 1'b1;
            case (mode)
                MODE_ADDR_IND: address = base;
                MODE_POSTINC: begin
                    address = base;
                    wr.en   = 1'b1;
                    wr.addr = {BANK_ADDR, reg_req};
                    wr.data = base + step;
                end
                MODE_PREDEC: begin
                    address = base - step;
                    wr.en   = 1'b1;
                    wr.addr = {BANK_ADDR, reg_req};
                    wr.data = base - step;
                end
                MODE_DISP: begin
                    address    = base + sext16(ext_first);
                    words_used = 2'd1;
                end
                MODE_INDEX: begin
                    address    = index_addr;
                    words_used = 2'd1;
                end
                default: begin
                    case (reg_req)
                        EXT_ABS_W: begin
                            address    = sext16(ext_first);
                            words_used = 2'd1;
                        end
                        EXT_ABS_L: begin
                            address    = {ext_first, ext_second};
                            words_used = 2'd2;
                        end
                        EXT_PC_DISP: begin
                            address    = pc + sext16(ext_first);
                            words_used = 2'd1;
                        end
                        default: begin
                            address    = index_addr;
                            words_used = 2'd1;
                        end
                    endcase
                end
            endcase
            // word and long operands must be even
            if (size != OPSZ_BYTE && address[0]) begin
                status = STATUS_ODD;
            end
        end
    end

endmodule

/* src/m68k_effective_address_unit.sv */
// ----------------------------------------------------------------------------
// m68k_effective_address_unit
// 68000 effective address resolution with the D0-D7 / A0-A7 register file.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operand request (action, mode, register, size, two
//   extension words, pc, write value) under s_valid / s_ready. m_* returns
//   one result per request (memory flag, address, operand value, extension
//   words used, status) under m_valid / m_ready.
//   Pipeline: a request accepted into the input register is computed from
//   it and loaded into the output register, where it is presented on m_*.
//   Throughput: one request per cycle while m_ready is high. The register
//   file is read when a request is taken into the input register and
//   written as its result is loaded into the output register; a write on
//   that edge is bypassed to the request read at the same time, so
//   back-to-back requests see every earlier update.
//   Stall: while m_ready is low the result holds; the input register still
//   takes one more request, then s_ready drops until the result leaves.
//   Reset: both stages empty, all D and A registers read as zero.
// ----------------------------------------------------------------------------
module m68k_effective_address_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [2:0]  s_mode,
    input  logic [2:0]  s_reg_req,
    input  logic [1:0]  s_size,
    input  logic [15:0] s_ext_first,
    input  logic [15:0] s_ext_second,
    input  logic [31:0] s_pc,
    input  logic [31:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_memory,
    output logic [31:0] m_address,
    output logic [31:0] m_operand_value,
    output logic [1:0]  m_words_used,
    output logic [1:0]  m_status
);
    import m68kea_pkg::*;

    // input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        action_reg;
    logic [2:0]  mode_reg;
    logic [2:0]  reg_req_reg;
    logic [1:0]  size_reg;
    logic [15:0] ext_first_reg;
    logic [15:0] ext_second_reg;
    word_t       pc_reg;
    word_t       write_value_reg;

    // output stage
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        is_memory_reg;
    word_t       address_reg;
    word_t       operand_value_reg;
    logic [1:0]  words_used_reg;
    logic [1:0]  status_reg;

    logic        accept;
    logic        advance;
    rf_addr_t    rd_addr_a;
    rf_addr_t    rd_addr_b;
    word_t       rd_data_a;
    word_t       rd_data_b;
    rf_write_t   calc_wr;
    rf_write_t   commit_wr;
    logic        calc_is_memory;
    word_t       calc_address;
    word_t       calc_operand_value;
    logic [1:0]  calc_words_used;
    logic [1:0]  calc_status;

    // handshake
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign in_valid_next = accept || (in_valid_reg && !advance);
    assign m_valid_next  = advance || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // capture the request
    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg      <= s_action;
            mode_reg        <= s_mode;
            reg_req_reg     <= s_reg_req;
            size_reg        <= s_size;
            ext_first_reg   <= s_ext_first;
            ext_second_reg  <= s_ext_second;
            pc_reg          <= s_pc;
            write_value_reg <= s_write_value;
        end
    end

    // base register: Dn for data direct, An otherwise; index from brief word
    assign rd_addr_a = {(s_mode == MODE_DN) ? BANK_DATA : BANK_ADDR, s_reg_req};
    assign rd_addr_b = {s_ext_first[15], s_ext_first[14:12]};

    // register update lands with the result
    always_comb begin
        commit_wr    = calc_wr;
        commit_wr.en = calc_wr.en && advance;
    end

    m68kea_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr        (commit_wr)
    );

    m68kea_calc u_calc (
        .action        (action_reg),
        .mode          (mode_reg),
        .reg_req       (reg_req_reg),
        .size          (size_reg),
        .ext_first     (ext_first_reg),
        .ext_second    (ext_second_reg),
        .pc            (pc_reg),
        .write_value   (write_value_reg),
        .base          (rd_data_a),
        .idx_data      (rd_data_b),
        .is_memory     (calc_is_memory),
        .address       (calc_address),
        .operand_value (calc_operand_value),
        .words_used    (calc_words_used),
        .status        (calc_status),
        .wr            (calc_wr)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            is_memory_reg     <= calc_is_memory;
            address_reg       <= calc_address;
            operand_value_reg <= calc_operand_value;
            words_used_reg    <= calc_words_used;
            status_reg        <= calc_status;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_is_memory     = is_memory_reg;
    assign m_address       = address_reg;
    assign m_operand_value = operand_value_reg;
    assign m_words_used    = words_used_reg;
    assign m_status        = status_reg;

    // input stage only blocks when both stages are full and the output stalls
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("s_ready low without a full, stalled pipeline");

    // a request moving forward always shows up as a result
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("advanced request did not reach the output");

    // register file is only written from a request that is advancing
    a_commit_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_wr.en |-> (in_valid_reg && advance))
        else $error("register write without an advancing request");

    // an odd address fault only comes with a memory operand
    a_odd_is_memory: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status == STATUS_ODD) |-> m_is_memory)
        else $error("odd address status on a non-memory operand");

    // an invalid request reports nothing else
    a_invalid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status == STATUS_INVALID)
            |-> (!m_is_memory && m_words_used == 2'd0 && m_address == '0))
        else $error("invalid request with non-zero result fields");

endmodule
